// File: sv/can_frame_batch_flush_decider_macros.svh
// Assertion helpers used by the decider's top-level RTL.
`ifndef CAN_FRAME_BATCH_FLUSH_DECIDER_MACROS_SVH
`define CAN_FRAME_BATCH_FLUSH_DECIDER_MACROS_SVH

// Same-cycle implication, masked while reset is active.
`define CFBFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is active.
`define CFBFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/cfbfd_pkg.sv
`timescale 1ns / 1ps
package cfbfd_pkg;

	// Field widths
	localparam int ID_W      = 11;
	localparam int DLC_W     = 4;
	localparam int PAYLOAD_W = 64;
	localparam int TIME_W    = 32;
	localparam int POS_W     = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// Identifier table depth and slot index width
	localparam int ID_ENTRIES = 2048;
	localparam int SLOT_W     = $clog2(ID_ENTRIES);

	// Reduction of an identifier onto the table: conditional subtract steps
	localparam int MOD_STEPS = 8;
	localparam int MOD_W     = 24;

	// Products of a time value and a percentage, and their scaled sums
	localparam int PROD_W   = TIME_W + CFG_W;
	localparam int SCALED_W = PROD_W + 1;

	localparam logic [CFG_W-1:0] PAYLOAD_CAPACITY = 7'd93;
	localparam logic [CFG_W-1:0] LIMIT_RESET      = 7'd93;
	localparam logic [CFG_W-1:0] PERCENT_RESET    = 7'd5;
	localparam int               PERCENT_SCALE    = 100;

	// One full wrap of the time stamp, expressed in scaled units
	localparam logic [SCALED_W-1:0] SCALED_WRAP = SCALED_W'(PERCENT_SCALE) << TIME_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_PERCENT = 1'd1;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic [ID_W-1:0]      can_id;
		logic [DLC_W-1:0]     dlc;
		logic [PAYLOAD_W-1:0] payload;
		logic [TIME_W-1:0]    arrival_us;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]      out_id;
		logic [DLC_W-1:0]     out_dlc;
		logic [PAYLOAD_W-1:0] out_payload;
		logic [POS_W-1:0]     position;
		logic                 end_of_batch;
	} out_item_t;

	// One identifier's table entry
	typedef struct packed {
		logic              seen;
		logic [TIME_W-1:0] period;
		logic [TIME_W-1:0] last;
	} entry_t;

	// Item handed from the table stage to the batch stage
	typedef struct packed {
		in_item_t          item;
		logic              seen;
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] now_scaled;
	} stage_t;

	// Map an identifier onto a table slot (identifier modulo table depth)
	function automatic slot_t slot_of(input logic [ID_W-1:0] id);
		logic [MOD_W-1:0] v;
		v = MOD_W'(id);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (v >= (MOD_W'(ID_ENTRIES) << k)) begin
				v = v - (MOD_W'(ID_ENTRIES) << k);
			end
		end
		return v[SLOT_W-1:0];
	endfunction

	// Clamp the batch limit into one to payload capacity
	function automatic logic [CFG_W-1:0] effective_limit(input logic [CFG_W-1:0] lim);
		logic [CFG_W-1:0] r;
		r = lim;
		if (lim == '0) begin
			r = CFG_W'(1);
		end else if (lim > PAYLOAD_CAPACITY) begin
			r = PAYLOAD_CAPACITY;
		end
		return r;
	endfunction

endpackage

// File: sv/cfbfd_id_table.sv
`timescale 1ns / 1ps
module cfbfd_id_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  cfbfd_pkg::slot_t rd_addr,
	input  logic             wr_en,
	input  cfbfd_pkg::slot_t wr_addr,
	input  cfbfd_pkg::entry_t wr_data,
	output cfbfd_pkg::entry_t rd_data,
	output logic             busy
);
	import cfbfd_pkg::*;

	entry_t mem [ID_ENTRIES];
	entry_t rd_q;
	entry_t fwd_data_q;
	logic   fwd_q;
	slot_t  clr_idx_q;
	logic   busy_q;

	// Sweep the table clear after reset, then track read/write collisions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
			fwd_q     <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_idx_q <= clr_idx_q + SLOT_W'(1);
				if (clr_idx_q == SLOT_W'(ID_ENTRIES - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (rd_en) begin
				fwd_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// Write one entry, register the read data and the concurrent write data
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// Forward the write that landed on the same slot as the read
	assign rd_data = fwd_q ? fwd_data_q : rd_q;
	assign busy    = busy_q;

endmodule

// File: sv/cfbfd_batch.sv
`timescale 1ns / 1ps
module cfbfd_batch (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cfbfd_pkg::CFG_W-1:0] batch_limit,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  cfbfd_pkg::stage_t           up,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cfbfd_pkg::out_item_t        out_item
);
	import cfbfd_pkg::*;

	logic              vld_s2;
	stage_t            stg_s2;
	logic              out_valid_q;
	out_item_t         out_q;
	logic [POS_W-1:0]  frames_q;
	logic [TIME_W-1:0] start_q;
	logic [SCALED_W-1:0] thr_q;

	logic                adv_s2;
	logic [POS_W-1:0]    count;
	logic [CFG_W-1:0]    lim;
	logic                first;
	logic                borrow;
	logic [SCALED_W-1:0] waited_scaled;
	logic [SCALED_W-1:0] thr_next;
	logic                flush;

	assign adv_s2   = vld_s2 && (!out_valid_q || out_ready);
	assign up_ready = !vld_s2 || adv_s2;

	// Decide whether the batch closes after this item
	always_comb begin
		count  = frames_q + POS_W'(1);
		lim    = effective_limit(batch_limit);
		first  = (frames_q == '0);
		borrow = stg_s2.item.arrival_us < start_q;
		waited_scaled = SCALED_W'(stg_s2.now_scaled) + (borrow ? SCALED_WRAP : '0);
		thr_next = SCALED_W'(stg_s2.now_scaled) + SCALED_W'(stg_s2.prod)
			- SCALED_W'(PERCENT_SCALE - 1);
		priority if (count >= lim) begin
			flush = 1'b1;
		end else if (first) begin
			flush = !stg_s2.seen || (stg_s2.prod < PROD_W'(PERCENT_SCALE));
		end else begin
			flush = waited_scaled >= thr_q;
		end
	end

	// Advance valid flags and batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			frames_q    <= '0;
			start_q     <= '0;
			thr_q       <= '0;
		end else begin
			if (up_ready) begin
				vld_s2 <= up_valid;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv_s2) begin
				frames_q <= flush ? '0 : count;
				if (first) begin
					start_q <= stg_s2.item.arrival_us;
					thr_q   <= thr_next;
				end
			end
		end
	end

	// Hold payloads of the stage and output registers
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			stg_s2 <= up;
		end
		if (adv_s2) begin
			out_q.out_id       <= stg_s2.item.can_id;
			out_q.out_dlc      <= stg_s2.item.dlc;
			out_q.out_payload  <= stg_s2.item.payload;
			out_q.position     <= count;
			out_q.end_of_batch <= flush;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: sv/can_frame_batch_flush_decider.sv
`timescale 1ns / 1ps
`include "can_frame_batch_flush_decider_macros.svh"
// CAN frame batch flush decider. Each accepted frame yields exactly one result
// item carrying the frame unchanged, its position in the current Ethernet
// batch and an end-of-batch flag. The block sustains one item per clock while
// out_ready stays high: each frame does one read-modify-write of its
// identifier's table entry (seen bit, last arrival, last period) in a
// single-port-write memory, and a back-to-back frame on the same identifier
// takes the just-written entry through a forwarding path. A frame passes the
// table stage, the batch stage and the output register before out_valid. After
// reset the table is cleared over all ID_ENTRIES slots (2048 by default),
// during which in_ready stays low; configuration writes are taken at any time.
module can_frame_batch_flush_decider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfbfd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cfbfd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cfbfd_pkg::in_item_t             in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cfbfd_pkg::out_item_t            out_item
);
	import cfbfd_pkg::*;

	logic [CFG_W-1:0] batch_limit_q;
	logic [CFG_W-1:0] queue_percent_q;

	logic     vld_s1;
	in_item_t item_s1;
	slot_t    slot_s1;

	logic     busy;
	logic     in_acc;
	logic     adv_s1;
	logic     up_ready;
	slot_t    slot_in;
	entry_t   ent_cur;
	entry_t   ent_new;
	stage_t   stage;
	logic [CFG_W-1:0] eff_lim;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_limit_q   <= LIMIT_RESET;
			queue_percent_q <= PERCENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_BATCH_LIMIT:   batch_limit_q   <= cfg_data;
				CFG_QUEUE_PERCENT: queue_percent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input handshake and table read address
	assign adv_s1   = vld_s1 && up_ready;
	assign in_ready = !busy && (!vld_s1 || adv_s1);
	assign in_acc   = in_valid && in_ready;
	assign slot_in  = slot_of(in_item.can_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || adv_s1) begin
			vld_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_item;
			slot_s1 <= slot_in;
		end
	end

	cfbfd_id_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (slot_in),
		.wr_en   (adv_s1),
		.wr_addr (slot_s1),
		.wr_data (ent_new),
		.rd_data (ent_cur),
		.busy    (busy)
	);

	// Update the entry and scale the old period and the stamp
	always_comb begin
		ent_new.seen   = 1'b1;
		ent_new.last   = item_s1.arrival_us;
		ent_new.period = ent_cur.seen ? (item_s1.arrival_us - ent_cur.last) : ent_cur.period;

		stage.item       = item_s1;
		stage.seen       = ent_cur.seen;
		stage.prod       = PROD_W'(ent_cur.period) * PROD_W'(queue_percent_q);
		stage.now_scaled = PROD_W'(item_s1.arrival_us) * PROD_W'(PERCENT_SCALE);
	end

	cfbfd_batch u_batch (
		.clk         (clk),
		.arst_n      (arst_n),
		.batch_limit (batch_limit_q),
		.up_valid    (vld_s1),
		.up_ready    (up_ready),
		.up          (stage),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

	assign eff_lim = effective_limit(batch_limit_q);

	`CFBFD_ASSERT_IMPL(a_pos_range, clk, arst_n, out_valid, (out_item.position != '0) && (out_item.position <= PAYLOAD_CAPACITY), "position outside payload capacity")
	`CFBFD_ASSERT_IMPL(a_limit_flush, clk, arst_n, out_valid && (out_item.position == eff_lim), out_item.end_of_batch, "full batch not flushed")
	`CFBFD_ASSERT_IMPL(a_clear_idle, clk, arst_n, busy, !vld_s1 && !in_ready, "item in flight during table clear")
	`CFBFD_ASSERT_NEXT(a_s1_hold, clk, arst_n, vld_s1 && !adv_s1, vld_s1 && $stable(slot_s1), "stalled table stage lost its slot")

endmodule

// File: tb/flush_decision_checker.sv
`timescale 1ns / 1ps
module flush_decision_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfbfd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cfbfd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  cfbfd_pkg::in_item_t             in_item,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  cfbfd_pkg::out_item_t            out_item,
	output int                              fail_count,
	output int                              outstanding,
	output int                              frames_done,
	output int                              batches_done
);
	import cfbfd_pkg::*;

	// Per-identifier history
	logic              seen_tbl   [ID_ENTRIES];
	logic [TIME_W-1:0] last_tbl   [ID_ENTRIES];
	logic [TIME_W-1:0] period_tbl [ID_ENTRIES];

	// Open batch and shadow copies of the registers
	int                batch_fill;
	logic [TIME_W-1:0] start_us;
	logic              lead_seen;
	logic [TIME_W-1:0] lead_period;
	logic [CFG_W-1:0]  limit_reg;
	logic [CFG_W-1:0]  pct_reg;

	out_item_t pending_results [$];
	out_item_t want;
	int        mismatches;
	int        checked;
	int        closed;

	// Work out the result item for one frame and advance the tables
	function automatic out_item_t decide_frame(input in_item_t f);
		out_item_t         r;
		int                slot;
		int                fill;
		int                cap;
		logic [TIME_W-1:0] waited;
		logic [63:0]       allowed;
		logic              flush;
		slot = int'(f.can_id) % ID_ENTRIES;
		// snapshot the lead frame before its own entry is updated
		if (batch_fill == 0) begin
			start_us    = f.arrival_us;
			lead_seen   = seen_tbl[slot];
			lead_period = period_tbl[slot];
		end
		if (seen_tbl[slot]) begin
			period_tbl[slot] = f.arrival_us - last_tbl[slot];
		end
		last_tbl[slot] = f.arrival_us;
		seen_tbl[slot] = 1'b1;
		fill = batch_fill + 1;
		// zero acts as one, anything past capacity acts as capacity
		if (limit_reg == '0) begin
			cap = 1;
		end else if (limit_reg > PAYLOAD_CAPACITY) begin
			cap = int'(PAYLOAD_CAPACITY);
		end else begin
			cap = int'(limit_reg);
		end
		waited  = f.arrival_us - start_us;
		allowed = (64'(lead_period) * 64'(pct_reg)) / 64'(PERCENT_SCALE);
		flush   = (fill >= cap) || !lead_seen || (64'(waited) >= allowed);
		r.out_id       = f.can_id;
		r.out_dlc      = f.dlc;
		r.out_payload  = f.payload;
		r.position     = POS_W'(fill);
		r.end_of_batch = flush;
		batch_fill = flush ? 0 : fill;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			mismatches++;
		end
	endtask

	// Predict on input items, compare on result items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ID_ENTRIES; k++) begin
				seen_tbl[k]   = 1'b0;
				last_tbl[k]   = '0;
				period_tbl[k] = '0;
			end
			batch_fill  = 0;
			start_us    = '0;
			lead_seen   = 1'b0;
			lead_period = '0;
			limit_reg   = LIMIT_RESET;
			pct_reg     = PERCENT_RESET;
			pending_results.delete();
			mismatches  = 0;
			checked     = 0;
			closed      = 0;
			fail_count   <= 0;
			outstanding  <= 0;
			frames_done  <= 0;
			batches_done <= 0;
		end else begin
			if (cfg_we === 1'b1) begin
				case (cfg_idx)
					CFG_BATCH_LIMIT: begin
						limit_reg = cfg_data;
					end
					CFG_QUEUE_PERCENT: begin
						pct_reg = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				pending_results.push_back(decide_frame(in_item));
			end
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result item, expected none, got id %0h",
						$time, out_item.out_id);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("out_id", 64'(want.out_id), 64'(out_item.out_id));
					check_field("out_dlc", 64'(want.out_dlc), 64'(out_item.out_dlc));
					check_field("out_payload", want.out_payload, out_item.out_payload);
					check_field("position", 64'(want.position), 64'(out_item.position));
					check_field("end_of_batch", 64'(want.end_of_batch),
						64'(out_item.end_of_batch));
					checked++;
					if (want.end_of_batch) begin
						closed++;
					end
				end
			end
			fail_count   <= mismatches;
			outstanding  <= pending_results.size();
			frames_done  <= checked;
			batches_done <= closed;
		end
	end

endmodule

// File: tb/tb_can_frame_batch_flush_decider.sv
`timescale 1ns / 1ps
module tb_can_frame_batch_flush_decider;
	import cfbfd_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 240;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 10;
	localparam int POOL_SIZE   = 8;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx  = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_item  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_item;

	int fail_count;
	int outstanding;
	int frames_done;
	int batches_done;

	int                idle_pct      = 0;
	int                stall_pct     = 0;
	int                settings_used = 1;
	int                cycle_count   = 0;
	logic [TIME_W-1:0] clock_us      = '0;
	logic [ID_W-1:0]   id_pool [POOL_SIZE];
	logic [CFG_W-1:0]  lim_sel;
	logic [CFG_W-1:0]  pct_sel;

	can_frame_batch_flush_decider u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	flush_decision_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_item     (out_item),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.frames_done  (frames_done),
		.batches_done (batches_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result side at the current rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Mostly legal codes, sometimes the unused upper ones
	function automatic logic [DLC_W-1:0] random_dlc();
		if ($urandom_range(9) == 0) begin
			return DLC_W'($urandom_range(15));
		end
		return DLC_W'($urandom_range(8));
	endfunction

	// Offer one frame after an optional idle gap and hold it until taken
	task automatic send_frame(input logic [ID_W-1:0] f_id, input logic [DLC_W-1:0] f_dlc,
			input logic [PAYLOAD_W-1:0] f_data, input logic [TIME_W-1:0] f_stamp);
		in_item_t f;
		f.can_id     = f_id;
		f.dlc        = f_dlc;
		f.payload    = f_data;
		f.arrival_us = f_stamp;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_item  <= f;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	// Hold off the sender until every result item is back
	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Periodic traffic on a small identifier pool, with bursts and noise
	task automatic send_traffic(input int count);
		int sent;
		int kind;
		int tail;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if (kind < 5) begin
				// slow lead frame, then a fast tail riding on its long period
				clock_us += $urandom_range(60000, 20000);
				send_frame(id_pool[0], random_dlc(), {$urandom(), $urandom()}, clock_us);
				tail = $urandom_range(100, 20);
				repeat (tail) begin
					clock_us += $urandom_range(3);
					send_frame(id_pool[$urandom_range(POOL_SIZE - 1, 1)], random_dlc(),
						{$urandom(), $urandom()}, clock_us);
				end
				sent += tail + 1;
			end else if (kind < 15) begin
				// stray identifier and stamp anywhere in range
				send_frame(ID_W'($urandom_range(2047)), random_dlc(),
					{$urandom(), $urandom()}, $urandom());
				sent++;
			end else if (kind < 16) begin
				wait_results();
			end else begin
				clock_us += $urandom_range(40);
				send_frame(id_pool[$urandom_range(POOL_SIZE - 1, 1)], random_dlc(),
					{$urandom(), $urandom()}, clock_us);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at reset settings
		// unseen lead closes at once, then zero allowance closes too
		send_frame(11'd0, 4'd0, 64'h0, 32'd0);
		send_frame(11'd0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1000);
		// allowance of 50 us keeps the batch open until it runs out
		send_frame(11'd0, 4'd1, 64'h0123_4567_89AB_CDEF, 32'd2000);
		send_frame(11'd5, 4'd2, 64'h8000_0000_0000_0001, 32'd2010);
		send_frame(11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2060);
		send_frame(11'd2047, 4'd4, 64'h0, 32'd3060);
		// period taken across the stamp wrap
		send_frame(11'd1024, 4'd3, 64'hA5A5_5A5A_A5A5_5A5A, 32'hFFFF_FF00);
		send_frame(11'd1024, 4'd5, 64'h5A5A_A5A5_5A5A_A5A5, 32'h0000_0300);
		send_frame(11'd1024, 4'd6, 64'h0F0F_0F0F_F0F0_F0F0, 32'h0000_0700);
		send_frame(11'd3, 4'd7, 64'hF0F0_F0F0_0F0F_0F0F, 32'h0000_0720);
		send_frame(11'd3, 4'd8, 64'h1111_2222_3333_4444, 32'h0000_0740);
		// batch opened just before the wrap, waited time wraps as well
		send_frame(11'd1024, 4'd0, 64'h5555_6666_7777_8888, 32'hFFFF_FFF0);
		send_frame(11'd9, 4'd1, 64'h9999_AAAA_BBBB_CCCC, 32'h0000_0010);
		send_frame(11'd9, 4'd2, 64'hDDDD_EEEE_FFFF_0000, 32'h0000_0040);
		// huge period needs the wide product
		send_frame(11'd1024, 4'd4, 64'h7FFF_FFFF_FFFF_FFFE, 32'h0000_0050);
		send_frame(11'd2047, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0060);
		send_frame(11'd0, 4'd8, 64'h0, 32'h8000_0000);
		wait_results();

		// Random phases, each with its own settings and one of four idling modes
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin lim_sel = LIMIT_RESET;      pct_sel = PERCENT_RESET; end
				1: begin lim_sel = 7'd0;             pct_sel = 7'd100;        end
				2: begin lim_sel = 7'd127;           pct_sel = 7'd127;        end
				3: begin lim_sel = 7'd4;             pct_sel = 7'd127;        end
				4: begin lim_sel = PAYLOAD_CAPACITY; pct_sel = 7'd0;          end
				5: begin lim_sel = 7'd1;             pct_sel = 7'd50;         end
				6: begin lim_sel = 7'd16;            pct_sel = 7'd100;        end
				default: begin lim_sel = PAYLOAD_CAPACITY; pct_sel = 7'd100; end
			endcase
			write_reg(CFG_BATCH_LIMIT, lim_sel);
			write_reg(CFG_QUEUE_PERCENT, pct_sel);
			settings_used++;
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 80; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 80; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			for (int k = 0; k < POOL_SIZE; k++) begin
				id_pool[k] = ID_W'($urandom_range(2047));
			end
			// start some phases close to the stamp wrap
			clock_us = (p % 3 == 0) ? 32'hFFFF_0000 + $urandom_range(32'hF000) : $urandom();
			send_traffic(PHASE_ITEMS);
			wait_results();
		end

		idle_pct  = 0;
		stall_pct = 0;
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d frames closing %0d batches under %0d register settings.",
			frames_done, batches_done, settings_used);
		$display("Idle and stall mixes, stamp wraps, long bursts and stray ids were included.");
		if (fail_count == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Run guard
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

endmodule
